>>> design/bale_pkg.sv
// Shared types and constants for the bounded array list engine.
package bale_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VAL_W        = 32;
  localparam int OP_W         = 3;
  localparam int POS_W        = 5;
  localparam int CNT_W        = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT  = 3'd0,
    OP_INS_REAR   = 3'd1,
    OP_INS_AT     = 3'd2,
    OP_INS_SORTED = 3'd3,
    OP_DEL_FRONT  = 3'd4,
    OP_DEL_REAR   = 3'd5,
    OP_DEL_ITEM   = 3'd6,
    OP_READ       = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_ROT
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e               mode;
    logic                     sorted;
    logic                     del_front;
    logic signed [VAL_W-1:0]  value;
  } cell_ctrl_t;

  typedef struct packed {
    logic                     ins_g;
    logic                     eq_seen;
    logic signed [VAL_W-1:0]  value;
  } cell_up_t;

  typedef struct packed {
    logic                     le_seen;
    logic signed [VAL_W-1:0]  value;
  } cell_dn_t;

endpackage

>>> design/bale_intf.sv
// Request and result channel interfaces of the bounded array list engine.
interface bale_req_if;
  import bale_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         opcode;
  logic signed [VAL_W-1:0] item_value;
  logic [POS_W-1:0]        position;

  modport source (output valid, opcode, item_value, position, input ready);
  modport sink   (input valid, opcode, item_value, position, output ready);
endinterface

interface bale_res_if;
  import bale_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    ok;
  logic [CNT_W-1:0]        count_after;
  logic signed [VAL_W-1:0] element;
  logic                    element_valid;
  logic                    last;

  modport source (output valid, ok, count_after, element, element_valid, last, input ready);
  modport sink   (input valid, ok, count_after, element, element_valid, last, output ready);
endinterface

>>> design/bale_cell.sv
// One list slot: holds an entry and shifts, inserts or rotates with its neighbors.
module bale_cell #(
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic                  clk_i,
  input  bale_pkg::cell_ctrl_t  ctrl_i,
  input  logic [CW-1:0]         count_i,
  input  logic [CW-1:0]         ins_idx_i,
  input  bale_pkg::cell_up_t    lo_i,
  input  bale_pkg::cell_dn_t    hi_i,
  output bale_pkg::cell_up_t    up_o,
  output bale_pkg::cell_dn_t    dn_o
);
  import bale_pkg::*;

  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  logic signed [VAL_W-1:0] entry_q, entry_d;
  logic occ, le, eq, le_seen, eq_seen, g, is_top;

  assign occ     = IDX_C < count_i;
  assign le      = occ && !(entry_q > ctrl_i.value);
  assign eq      = occ && (entry_q == ctrl_i.value);
  assign le_seen = le | hi_i.le_seen;
  assign eq_seen = eq | lo_i.eq_seen;
  assign g       = ctrl_i.sorted ? !le_seen : (IDX_C >= ins_idx_i);
  assign is_top  = IDX_C == (count_i - CW'(1));

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.mode)
      CELL_INS: begin
        if (lo_i.ins_g) begin
          entry_d = lo_i.value;
        end else if (g) begin
          entry_d = ctrl_i.value;
        end
      end
      CELL_DEL: begin
        if (ctrl_i.del_front || eq_seen) begin
          entry_d = hi_i.value;
        end
      end
      CELL_ROT: begin
        entry_d = is_top ? ctrl_i.value : hi_i.value;
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign up_o.ins_g   = g;
  assign up_o.eq_seen = eq_seen;
  assign up_o.value   = entry_q;
  assign dn_o.le_seen = le_seen;
  assign dn_o.value   = entry_q;

endmodule

>>> design/bounded_array_list_engine.sv
// Top level of the bounded array list engine: cell row, sequencer and result register.
//
// The list lives in a row of CAPACITY cells; every edit (insert front, rear, at a
// position or in sorted order, delete front, rear or a matching value) takes effect
// in the cycle the request is accepted, and its single result appears in the result
// register on the next cycle, so edits run at one request per cycle while results
// are taken. Sorted insert and delete item resolve their slot through a compare
// chain that ripples along the row. A read out rotates the occupied cells toward
// the front and sends the front cell out each cycle while results are taken (a
// single empty result when the list is empty), leaving the list as it was after the
// last entry; no new request is taken until that last entry has been loaded.
module bounded_array_list_engine #(
  parameter int CAPACITY = bale_pkg::CAPACITY_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bale_req_if.sink   req_i,
  bale_res_if.source res_o
);
  import bale_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic {ST_IDLE, ST_READ} state_e;

  state_e                  state_q;
  logic [CW-1:0]           count_q, rd_idx_q;
  logic                    out_valid_q, ok_q, ev_q, last_q;
  logic [CNT_W-1:0]        cnt_q;
  logic signed [VAL_W-1:0] elem_q;

  cell_ctrl_t              ctrl;
  logic [CW-1:0]           ins_idx, edit_cnt;
  logic                    edit_ok, out_free, acc, full, pos_ok, found;
  logic [PW-1:0]           pos_ext, cnt_ext;
  op_e                     op;
  logic signed [VAL_W-1:0] front_val;

  cell_up_t up_w [CAPACITY];
  cell_dn_t dn_w [CAPACITY];
  cell_up_t lo_w [CAPACITY];
  cell_dn_t hi_w [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_lo0
      assign lo_w[i] = '0;
    end else begin : g_lon
      assign lo_w[i] = up_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_hitop
      assign hi_w[i] = '0;
    end else begin : g_hin
      assign hi_w[i] = dn_w[i+1];
    end
    bale_cell #(.CW(CW), .IDX(i)) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .count_i   (count_q),
      .ins_idx_i (ins_idx),
      .lo_i      (lo_w[i]),
      .hi_i      (hi_w[i]),
      .up_o      (up_w[i]),
      .dn_o      (dn_w[i])
    );
  end

  assign front_val   = dn_w[0].value;
  assign found       = up_w[CAPACITY-1].eq_seen;
  assign out_free    = !out_valid_q || res_o.ready;
  assign req_i.ready = (state_q == ST_IDLE) && out_free;
  assign acc         = req_i.valid && req_i.ready;
  assign op          = op_e'(req_i.opcode);
  assign full        = count_q == CW'(CAPACITY);
  assign pos_ext     = PW'(req_i.position);
  assign cnt_ext     = PW'(count_q);
  assign pos_ok      = (pos_ext != '0) && (pos_ext <= cnt_ext);

  always_comb begin
    ctrl.mode      = CELL_HOLD;
    ctrl.sorted    = 1'b0;
    ctrl.del_front = 1'b0;
    ctrl.value     = req_i.item_value;
    ins_idx        = '0;
    edit_ok        = 1'b0;
    edit_cnt       = count_q;
    if (state_q == ST_READ) begin
      if (out_free) begin
        ctrl.mode  = CELL_ROT;
        ctrl.value = front_val;
      end
    end else if (acc) begin
      unique case (op)
        OP_INS_FRONT, OP_INS_REAR, OP_INS_AT, OP_INS_SORTED: begin
          edit_ok = !full && ((op != OP_INS_AT) || pos_ok);
          if (op == OP_INS_REAR) begin
            ins_idx = count_q;
          end else if (op == OP_INS_AT) begin
            ins_idx = CW'(pos_ext - PW'(1));
          end
          ctrl.sorted = op == OP_INS_SORTED;
          if (edit_ok) begin
            ctrl.mode = CELL_INS;
            edit_cnt  = count_q + CW'(1);
          end
        end
        OP_DEL_FRONT, OP_DEL_REAR: begin
          edit_ok = count_q != '0;
          ctrl.del_front = 1'b1;
          if (edit_ok) begin
            ctrl.mode = (op == OP_DEL_FRONT) ? CELL_DEL : CELL_HOLD;
            edit_cnt  = count_q - CW'(1);
          end
        end
        OP_DEL_ITEM: begin
          edit_ok   = found;
          ctrl.mode = CELL_DEL;
          if (found) begin
            edit_cnt = count_q - CW'(1);
          end
        end
        OP_READ: begin
          if (count_q != '0) begin
            ctrl.mode  = CELL_ROT;
            ctrl.value = front_val;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
      ok_q        <= 1'b0;
      cnt_q       <= '0;
      elem_q      <= '0;
      ev_q        <= 1'b0;
      last_q      <= 1'b0;
    end else if (acc) begin
      out_valid_q <= 1'b1;
      if (op != OP_READ) begin
        count_q <= edit_cnt;
        ok_q    <= edit_ok;
        cnt_q   <= CNT_W'(edit_cnt);
        elem_q  <= '0;
        ev_q    <= 1'b0;
        last_q  <= 1'b1;
      end else if (count_q == '0) begin
        ok_q   <= 1'b1;
        cnt_q  <= '0;
        elem_q <= '0;
        ev_q   <= 1'b0;
        last_q <= 1'b1;
      end else begin
        ok_q     <= 1'b1;
        cnt_q    <= CNT_W'(count_q);
        elem_q   <= front_val;
        ev_q     <= 1'b1;
        last_q   <= count_q == CW'(1);
        rd_idx_q <= CW'(1);
        if (count_q != CW'(1)) begin
          state_q <= ST_READ;
        end
      end
    end else if ((state_q == ST_READ) && out_free) begin
      out_valid_q <= 1'b1;
      ok_q        <= 1'b1;
      cnt_q       <= CNT_W'(count_q);
      elem_q      <= front_val;
      ev_q        <= 1'b1;
      last_q      <= rd_idx_q == (count_q - CW'(1));
      rd_idx_q    <= rd_idx_q + CW'(1);
      if (rd_idx_q == (count_q - CW'(1))) begin
        state_q <= ST_IDLE;
      end
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.ok            = ok_q;
  assign res_o.count_after   = cnt_q;
  assign res_o.element       = elem_q;
  assign res_o.element_valid = ev_q;
  assign res_o.last          = last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_edit_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (op != OP_READ) |=> out_valid_q && last_q && !ev_q)
    else $error("edit request did not produce a single final result");

  a_read_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> (count_q > CW'(1)) && (rd_idx_q < count_q))
    else $error("read out in progress with inconsistent index or count");

  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !acc |=> $stable(count_q))
    else $error("entry count changed without an accepted request");

endmodule
